/* hw/rtl/fbpa_pkg.sv */
// shared widths, codes and types of the fixed block pool allocator
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int ACTION_W   = 2;
    localparam int OFFSET_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int BSIZE_W    = 13;
    localparam int BCOUNT_W   = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_BLOCKS_DEF = 256;

    localparam logic [BSIZE_W-1:0]  BSIZE_RST  = 13'd16;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 9'd256;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_REBUILD = 2'd2,
        ACT_NONE    = 2'd3
    } fbpa_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_ALIGN = 2'd3
    } fbpa_status_t;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] quotient;
        logic [BSIZE_W-1:0]  remainder;
    } fbpa_div_rsp_t;

endpackage

/* hw/rtl/fixed_block_pool_allocator.sv */
// top level: request sequencer, head pointer and result register of the block pool
`timescale 1ns / 1ps

// Hands out equal-size blocks from a pool kept as a last-in first-out free list of
// block links in a single-port-read link store. One request is worked on at a time;
// the next one is taken as soon as the sequencer is back in idle, even while the
// previous result still waits on the result port. Allocate reads one link from the
// link store, the new head. Free does a range check against block_size * blocks in
// use, then runs a serial divider that gives the block index and the alignment
// remainder; a free that fails the range check answers straight from the check.
// Rebuild links every block in use, min(block_count, MAX_BLOCKS), and writes one link
// a cycle; with none in use it only sets the list empty. A result held up by a
// stalled result port waits in the hold stage and keeps the sequencer out of idle.
// An allocate finds the pool empty until a rebuild or a free has put a block in it;
// the link store has no reset, and only entries written by a rebuild or a free are
// ever read. Configuration writes are always taken and must only come while idle.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fbpa_pkg::ACTION_W-1:0]     s_action,
    input  logic [fbpa_pkg::OFFSET_W-1:0]     s_free_offset,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]     m_status,
    output logic [fbpa_pkg::OFFSET_W-1:0]     m_block_offset,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import fbpa_pkg::*;

    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [LINK_W-1:0] LINK_END = {LINK_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_CHECK,
        S_DIV,
        S_REBUILD,
        S_NOP,
        S_HOLD
    } state_t;

    state_t              state_reg,      state_next;
    logic [LINK_W-1:0]   head_reg,       head_next;
    logic [LINK_W-1:0]   rebuild_idx_reg, rebuild_idx_next;
    logic [BSIZE_W-1:0]  bsize_reg,      bsize_next;
    logic [BCOUNT_W-1:0] bcount_reg,     bcount_next;
    logic [OFFSET_W-1:0] offset_reg,     offset_next;
    logic                m_valid_reg,    m_valid_next;
    logic [STATUS_W-1:0] m_status_reg,   m_status_next;
    logic [OFFSET_W-1:0] m_offset_reg,   m_offset_next;
    logic [STATUS_W-1:0] hold_status_reg, hold_status_next;
    logic [OFFSET_W-1:0] hold_offset_reg, hold_offset_next;

    logic                s_accept;
    logic                out_free;
    logic                fin_valid;
    logic [STATUS_W-1:0] fin_status;
    logic [OFFSET_W-1:0] fin_offset;
    logic [LINK_W-1:0]   n_used;
    logic [LINK_W-1:0]   rebuild_idx_inc;
    logic [31:0]         limit;
    logic [31:0]         alloc_prod;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [LINK_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [LINK_W-1:0]   ram_rd_data;

    logic                div_start;
    fbpa_div_rsp_t       div_rsp;

    fbpa_link_ram #(
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    fbpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (offset_reg),
        .divisor  (bsize_reg),
        .rsp      (div_rsp)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // blocks in use, saturated at the store depth
    assign n_used = (32'(bcount_reg) > MAX_BLOCKS) ? LINK_W'(MAX_BLOCKS)
                                                   : LINK_W'(bcount_reg);
    assign limit      = 32'(bsize_reg) * 32'(n_used);
    assign alloc_prod = 32'(head_reg[IDX_W-1:0]) * 32'(bsize_reg);
    assign rebuild_idx_inc = rebuild_idx_reg + LINK_W'(1);

    // head is read at acceptance so the next link is there in the following cycle
    assign ram_rd_en = s_accept && (s_action == ACT_ALLOC);

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        rebuild_idx_next = rebuild_idx_reg;
        bsize_next       = bsize_reg;
        bcount_next      = bcount_reg;
        offset_next      = offset_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_offset_next    = m_offset_reg;
        hold_status_next = hold_status_reg;
        hold_offset_next = hold_offset_reg;
        fin_valid        = 1'b0;
        fin_status       = ST_OK;
        fin_offset       = '0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = '0;
        ram_wr_data      = '0;
        div_start        = 1'b0;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BLOCK_SIZE:  bsize_next  = cfg_data[BSIZE_W-1:0];
                REG_BLOCK_COUNT: bcount_next = cfg_data[BCOUNT_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    offset_next = s_free_offset;
                    case (s_action)
                        ACT_ALLOC:   state_next = S_ALLOC;
                        ACT_FREE:    state_next = S_CHECK;
                        ACT_REBUILD: begin
                            state_next       = S_REBUILD;
                            rebuild_idx_next = '0;
                        end
                        default:     state_next = S_NOP;
                    endcase
                end
            end
            S_ALLOC: begin
                fin_valid = 1'b1;
                if (32'(head_reg) >= MAX_BLOCKS) begin
                    fin_status = ST_EMPTY;
                end else begin
                    fin_offset = alloc_prod[OFFSET_W-1:0];
                    head_next  = ram_rd_data;
                end
            end
            S_CHECK: begin
                // range comes before alignment; a zero block size lands here too
                if (32'(offset_reg) >= limit) begin
                    fin_valid  = 1'b1;
                    fin_status = ST_RANGE;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    fin_valid = 1'b1;
                    if (div_rsp.remainder != '0) begin
                        fin_status = ST_ALIGN;
                    end else if (32'(div_rsp.quotient) >= MAX_BLOCKS) begin
                        fin_status = ST_RANGE;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = div_rsp.quotient[IDX_W-1:0];
                        ram_wr_data = head_reg;
                        head_next   = LINK_W'(div_rsp.quotient);
                    end
                end
            end
            S_REBUILD: begin
                if (n_used == '0) begin
                    fin_valid        = 1'b1;
                    head_next        = LINK_END;
                    rebuild_idx_next = '0;
                end else begin
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = rebuild_idx_reg[IDX_W-1:0];
                    ram_wr_data      = (rebuild_idx_inc < n_used) ? rebuild_idx_inc
                                                                  : LINK_END;
                    rebuild_idx_next = rebuild_idx_inc;
                    if (rebuild_idx_inc >= n_used) begin
                        fin_valid = 1'b1;
                        head_next = '0;
                    end
                end
            end
            S_NOP: begin
                fin_valid = 1'b1;
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = hold_status_reg;
                    m_offset_next = hold_offset_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // finished result goes straight out, or waits in the hold stage
        if (fin_valid) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_status_next = fin_status;
                m_offset_next = fin_offset;
                state_next    = S_IDLE;
            end else begin
                hold_status_next = fin_status;
                hold_offset_next = fin_offset;
                state_next       = S_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            head_reg        <= LINK_END;
            rebuild_idx_reg <= '0;
            bsize_reg       <= BSIZE_RST;
            bcount_reg      <= BCOUNT_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            rebuild_idx_reg <= rebuild_idx_next;
            bsize_reg       <= bsize_next;
            bcount_reg      <= bcount_next;
            m_valid_reg     <= m_valid_next;
        end
        offset_reg      <= offset_next;
        m_status_reg    <= m_status_next;
        m_offset_reg    <= m_offset_next;
        hold_status_reg <= hold_status_next;
        hold_offset_reg <= hold_offset_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_block_offset = m_offset_reg;

    // one request in flight: after acceptance the input side closes
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // only a successful allocate carries an offset
    a_offset_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_block_offset == '0))
        else $error("non-zero offset with failing status");

    // head is a block index or the terminator
    a_head_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(head_reg) < MAX_BLOCKS) || (head_reg == LINK_END))
        else $error("free list head out of range");

    // the rebuild walk never passes the store depth
    a_rebuild_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(rebuild_idx_reg) <= MAX_BLOCKS)
        else $error("rebuild index beyond store depth");

    // divider only started from the range check
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (state_reg == S_CHECK) && (32'(offset_reg) < limit))
        else $error("divider started outside range check");

endmodule

/* hw/rtl/fbpa_link_ram.sv */
// link store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module fbpa_link_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 9
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/fbpa_div.sv */
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fbpa_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [fbpa_pkg::OFFSET_W-1:0]   dividend,
    input  logic [fbpa_pkg::BSIZE_W-1:0]    divisor,
    output fbpa_pkg::fbpa_div_rsp_t         rsp
);

    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(OFFSET_W + 1);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [OFFSET_W-1:0] quo_reg,   quo_next;
    logic [BSIZE_W-1:0]  rem_reg,   rem_next;
    logic [BSIZE_W-1:0]  dsr_reg,   dsr_next;
    logic [BSIZE_W:0]    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[OFFSET_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OFFSET_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = BSIZE_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[OFFSET_W-2:0], 1'b1};
            end else begin
                rem_next = trial[BSIZE_W-1:0];
                quo_next = {quo_reg[OFFSET_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
